@@ design/lrip_pkg.sv @@
// Package for the lidar range image projection block.
// Holds image geometry, status codes, CORDIC table and shared types.
// No dependencies.
package lrip_pkg;

    localparam int ROWS = 16;
    localparam int COLS = 1800;
    localparam int CELLS = ROWS * COLS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CELL_W = $clog2(CELLS);
    localparam int CNT_W = $clog2(COLS + 1);
    localparam int CORDIC_STEPS = 31;
    localparam int STEP_W = 5;
    localparam int SQ_W = 50;

    localparam logic [2:0] ST_PLACED   = 3'd0;
    localparam logic [2:0] ST_RING_OUT = 3'd1;
    localparam logic [2:0] ST_SKIPPED  = 3'd2;
    localparam logic [2:0] ST_COL_OUT  = 3'd3;
    localparam logic [2:0] ST_NEAR     = 3'd4;
    localparam logic [2:0] ST_OCCUPIED = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    localparam logic [1:0] REG_COLUMN_MODE = 2'd0;
    localparam logic [1:0] REG_DOWNSAMPLE  = 2'd1;
    localparam logic [1:0] REG_MIN_RANGE   = 2'd2;

    // Classified item handed from front to back.
    typedef struct packed {
        logic               clear;
        logic [2:0]         early_status;
        logic               use_counter;
        logic               counter_full;
        logic [CNT_W-1:0]   counter_col;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [7:0]         intensity;
        logic [7:0]         ring;
    } lrip_item_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_CALC, BK_COL, BK_LOOKUP, BK_DECIDE, BK_OUT
    } lrip_back_state_t;

    function automatic logic [31:0] turn_tab(input logic [STEP_W-1:0] i);
        logic [31:0] t;
        case (i)
            5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;
            5'd2: t = 32'h09FB385B;  5'd3: t = 32'h051111D4;
            5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
            5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;
            5'd8: t = 32'h0028BE53;  5'd9: t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

endpackage

@@ design/lrip_front.sv @@
// Front part: accepts items, runs ring and downsample tests, arrival counters.
// Depends on lrip_pkg.
module lrip_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  logic signed [23:0]   pos_x,
    input  logic signed [23:0]   pos_y,
    input  logic signed [23:0]   pos_z,
    input  logic [7:0]           intensity,
    input  logic [7:0]           ring,
    input  logic                 column_mode,
    input  logic [6:0]           downsample_rate,
    output logic                 q_valid,
    output lrip_pkg::lrip_item_t q_item,
    input  logic                 q_pop
);
    import lrip_pkg::*;

    // Two-entry queue
    lrip_item_t          q_mem [2];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          count_reg;
    logic [CNT_W-1:0]    arrivals_reg [ROWS];
    logic [6:0]          rate;
    logic [6:0]          rem;
    lrip_item_t          item;
    logic                push;
    logic [ROW_W-1:0]    rix;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign rate     = (downsample_rate == 7'd0) ? 7'd1 : downsample_rate;
    assign rix      = ring[ROW_W-1:0];

    // Remainder of the row index by the rate, bounded restoring steps;
    // rings past the image are rejected before the remainder matters
    always_comb
    begin
        logic [8:0] r;
        r = 9'd0;
        for (int b = ROW_W - 1; b >= 0; b--)
        begin
            r = {r[7:0], rix[b]};
            if (r >= {2'b00, rate})
                r = r - {2'b00, rate};
        end
        rem = r[6:0];
    end

    always_comb
    begin
        item = '0;
        item.clear       = mode;
        item.x           = pos_x;
        item.y           = pos_y;
        item.z           = pos_z;
        item.intensity   = intensity;
        item.ring        = ring;
        item.use_counter = column_mode;
        item.early_status = ST_PLACED;
        if (!mode)
        begin
            if ({24'd0, ring} >= 32'(ROWS))
                item.early_status = ST_RING_OUT;
            else if (rem != 7'd0)
                item.early_status = ST_SKIPPED;
            else
            begin
                item.counter_col  = arrivals_reg[rix];
                item.counter_full = (32'(arrivals_reg[rix]) >= COLS);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
                arrivals_reg[i] <= '0;
        end
        else if (push)
        begin
            if (mode)
            begin
                for (int i = 0; i < ROWS; i++)
                    arrivals_reg[i] <= '0;
            end
            else if (column_mode && item.early_status == ST_PLACED && !item.counter_full)
                arrivals_reg[rix] <= arrivals_reg[rix] + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem[rd_ptr_reg];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0) else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
`endif
endmodule

@@ design/lrip_back.sv @@
// Back part: CORDIC atan2, bit-serial square root, occupancy map, result register.
// Depends on lrip_pkg.
module lrip_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  lrip_pkg::lrip_item_t q_item,
    output logic                 q_pop,
    input  logic [23:0]          min_range,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [7:0]           row,
    output logic [10:0]          column,
    output logic [15:0]          cell_index,
    output logic [23:0]          range,
    output logic signed [23:0]   out_x,
    output logic signed [23:0]   out_y,
    output logic signed [23:0]   out_z,
    output logic [7:0]           out_intensity
);
    import lrip_pkg::*;

    lrip_back_state_t state_reg, state_next;
    lrip_item_t       it_reg;
    logic [STEP_W-1:0] step_reg;

    // CORDIC state: 24-bit inputs << 30 with growth fit in 57 bits
    logic signed [56:0] cx_reg, cy_reg;
    logic signed [33:0] cz_reg;
    logic               az_zero_reg;
    // Square root state
    logic [SQ_W-1:0]    s_reg, res_reg;
    logic [SQ_W-1:0]    sq_acc_reg;
    logic [1:0]         sq_term_reg;
    logic               sq_phase_reg;
    logic [47:0]        prod_reg;

    logic               wipe_active_reg;
    logic [CELL_W-1:0]  wipe_addr_reg;
    logic               map [CELLS];
    logic               map_rd_reg;
    logic [CELL_W-1:0]  cell_reg;
    logic [10:0]        col_reg;
    logic               col_bad_reg;

    logic [2:0]         status_reg;
    logic [15:0]        cell_out_reg;
    logic               out_valid_reg;
    logic               placed;

    // atan2 after rounding, column arithmetic
    logic signed [18:0] ang;
    logic signed [33:0] zr;
    logic signed [31:0] prod_col;
    logic signed [31:0] c_raw;
    logic signed [31:0] c_wrap;

    always_comb
    begin
        zr  = cz_reg + 34'sd32768;
        ang = (cz_reg >= 0) ? 19'(zr >>> 16) : -19'((-cz_reg + 34'sd32768) >>> 16);
        // atan2 of the origin is zero
        if (az_zero_reg)
            ang = 19'sd0;
    end
    always_comb
    begin
        logic signed [31:0] n;
        n = prod_col;
        c_raw = 32'(COLS / 2) - ((n >= 0) ? ((n + 32'sd32768) >>> 16)
                                           : -((-n + 32'sd32768) >>> 16));
        c_wrap = c_raw;
        if (c_wrap >= COLS) c_wrap = c_wrap - COLS;
        if (c_wrap < 0)     c_wrap = c_wrap + COLS;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (q_valid && !wipe_active_reg && !out_valid_reg)
                    state_next = BK_CALC;
            BK_CALC:
                if (step_reg == 5'(CORDIC_STEPS - 1) && sq_phase_reg)
                    state_next = BK_COL;
            BK_COL:    state_next = BK_LOOKUP;
            BK_LOOKUP: state_next = BK_DECIDE;
            BK_DECIDE: state_next = BK_OUT;
            BK_OUT:    state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == BK_IDLE) && q_valid && !wipe_active_reg && !out_valid_reg;
    end

    assign placed = (status_reg == ST_PLACED);
    assign prod_col = 32'(ang - 19'sd16384) * 32'(COLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        logic signed [56:0] sx, sy;
        logic [SQ_W-1:0]    t;
        logic [SQ_W-1:0]    bit_v;
        logic signed [23:0] f;
        sx = '0; sy = '0; t = '0; bit_v = '0; f = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                // Load only on a start; hold the waiting result otherwise
                if (q_pop)
                begin
                    it_reg       <= q_item;
                    step_reg     <= '0;
                    sq_term_reg  <= 2'd0;
                    sq_phase_reg <= 1'b0;
                    sq_acc_reg   <= '0;
                    res_reg      <= '0;
                    prod_reg     <= 48'(q_item.x) * 48'(q_item.x);
                    az_zero_reg  <= (q_item.x == 24'sd0) && (q_item.y == 24'sd0);
                    // atan2(x, y): x-axis value = y, y-axis value = x
                    if (q_item.y < 0)
                    begin
                        cz_reg <= (q_item.x >= 0) ? 34'sh80000000 : -34'sh80000000;
                        cx_reg <= -(57'(q_item.y) <<< 30);
                        cy_reg <= -(57'(q_item.x) <<< 30);
                    end
                    else
                    begin
                        cz_reg <= '0;
                        cx_reg <= 57'(q_item.y) <<< 30;
                        cy_reg <= 57'(q_item.x) <<< 30;
                    end
                end
            end
            BK_CALC:
            begin
                // One CORDIC rotation per cycle
                sx = cx_reg >>> step_reg;
                sy = cy_reg >>> step_reg;
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + sy;
                    cy_reg <= cy_reg - sx;
                    cz_reg <= cz_reg + 34'(turn_tab(step_reg));
                end
                else
                begin
                    cx_reg <= cx_reg - sy;
                    cy_reg <= cy_reg + sx;
                    cz_reg <= cz_reg - 34'(turn_tab(step_reg));
                end
                // Square root: first sum the three squares, then 25 digit steps
                if (!sq_phase_reg)
                begin
                    sq_acc_reg <= sq_acc_reg + SQ_W'(prod_reg);
                    sq_term_reg <= sq_term_reg + 2'd1;
                    f = (sq_term_reg == 2'd0) ? it_reg.y : it_reg.z;
                    prod_reg <= 48'(f) * 48'(f);
                    if (sq_term_reg == 2'd2)
                    begin
                        sq_phase_reg <= 1'b1;
                        s_reg <= sq_acc_reg + SQ_W'(prod_reg);
                    end
                    step_reg <= step_reg + 5'd1;
                end
                else
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg >= 5'd3 && step_reg < 5'd28)
                    begin
                        bit_v = SQ_W'(1) << (2 * (27 - step_reg));
                        t = res_reg + bit_v;
                        if (s_reg >= t)
                        begin
                            s_reg   <= s_reg - t;
                            res_reg <= (res_reg >> 1) + bit_v;
                        end
                        else
                            res_reg <= res_reg >> 1;
                    end
                end
            end
            BK_COL:
            begin
                if (it_reg.use_counter)
                begin
                    col_reg     <= 11'(it_reg.counter_col);
                    col_bad_reg <= it_reg.counter_full;
                    cell_reg    <= CELL_W'(32'(it_reg.counter_col)
                                   + 32'(it_reg.ring) * COLS);
                end
                else
                begin
                    col_reg     <= 11'(c_wrap);
                    col_bad_reg <= 1'b0;
                    cell_reg    <= CELL_W'(c_wrap + 32'(it_reg.ring) * COLS);
                end
            end
            BK_LOOKUP: ;
            BK_DECIDE:
            begin
                cell_out_reg <= 16'(32'(cell_reg));
                if (it_reg.clear)
                    status_reg <= ST_CLEARED;
                else if (it_reg.early_status != ST_PLACED)
                    status_reg <= it_reg.early_status;
                else if (col_bad_reg)
                    status_reg <= ST_COL_OUT;
                else if (res_reg[23:0] < min_range)
                    status_reg <= ST_NEAR;
                else if (map_rd_reg)
                    status_reg <= ST_OCCUPIED;
                else
                    status_reg <= ST_PLACED;
            end
            BK_OUT: ;
            default: ;
        endcase
    end

    // Occupancy map with a clearing pass on reset and on a new-scan item
    always_ff @(posedge clk)
    begin
        if (wipe_active_reg)
            map[wipe_addr_reg] <= 1'b0;
        else if (state_reg == BK_OUT && placed)
            map[cell_reg] <= 1'b1;
        map_rd_reg <= map[cell_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_active_reg <= 1'b1;
            wipe_addr_reg   <= '0;
        end
        else if (wipe_active_reg)
        begin
            if (32'(wipe_addr_reg) == CELLS - 1)
                wipe_active_reg <= 1'b0;
            wipe_addr_reg <= wipe_addr_reg + 1'b1;
        end
        else if (state_reg == BK_OUT && it_reg.clear)
        begin
            wipe_active_reg <= 1'b1;
            wipe_addr_reg   <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == BK_OUT)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        logic pt, colok;
        pt    = !it_reg.clear;
        colok = pt && (status_reg == ST_PLACED || status_reg == ST_NEAR
                       || status_reg == ST_OCCUPIED);
        out_valid     = out_valid_reg;
        status        = status_reg;
        row           = pt ? it_reg.ring : 8'd0;
        column        = colok ? col_reg : 11'd0;
        cell_index    = (pt && placed) ? cell_out_reg : 16'd0;
        range         = pt ? res_reg[23:0] : 24'd0;
        out_x         = (pt && placed) ? it_reg.x : 24'sd0;
        out_y         = (pt && placed) ? it_reg.y : 24'sd0;
        out_z         = (pt && placed) ? it_reg.z : 24'sd0;
        out_intensity = (pt && placed) ? it_reg.intensity : 8'd0;
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg) else $error("result dropped");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !wipe_active_reg && !out_valid_reg) else $error("start while busy");
    a_out_from_fsm: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == BK_OUT) else $error("stray result");
`endif
endmodule

@@ design/lidar_range_image_projection.sv @@
// Top level of the lidar range image projection block.
// Depends on lrip_pkg, lrip_front and lrip_back.
//
// Places lidar points into a 16 x 1800 range image. Each item yields one result:
// the front accepts and classifies it (ring, downsample, arrival counter) into a
// two-entry queue; the back runs a 31-step CORDIC atan2 in parallel with a
// square-sum and 25-step bit-serial square root, then resolves the column, reads
// the occupancy map and registers the result. In the back a point is started from
// idle, runs the 31 CORDIC steps (the square root finishes inside them), then
// picks the column, reads the map, decides the status and raises the result, and
// then waits for the result handshake, since the back holds its result in place
// and starts nothing while it waits; output stall keeps it waiting. After reset
// and after every new-scan item the occupancy map is wiped one cell per cycle; no
// item starts in the back during that pass, though items still enter the queue
// and configuration writes are taken at any time.
module lidar_range_image_projection (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [23:0] pos_z,
    input  logic [7:0]         intensity,
    input  logic [7:0]         ring,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [7:0]         row,
    output logic [10:0]        column,
    output logic [15:0]        cell_index,
    output logic [23:0]        range,
    output logic signed [23:0] out_x,
    output logic signed [23:0] out_y,
    output logic signed [23:0] out_z,
    output logic [7:0]         out_intensity,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import lrip_pkg::*;

    logic        column_mode_reg;
    logic [6:0]  downsample_rate_reg;
    logic [23:0] min_range_reg;
    logic        q_valid, q_pop;
    lrip_item_t  q_item;

    assign cfg_ready = 1'b1;

    // Register file: drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_mode_reg     <= 1'b0;
            downsample_rate_reg <= 7'd1;
            min_range_reg       <= 24'd1024;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COLUMN_MODE: column_mode_reg     <= cfg_data[0];
                REG_DOWNSAMPLE:  downsample_rate_reg <= cfg_data[6:0];
                REG_MIN_RANGE:   min_range_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    lrip_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .mode, .pos_x, .pos_y, .pos_z,
        .intensity, .ring,
        .column_mode(column_mode_reg), .downsample_rate(downsample_rate_reg),
        .q_valid, .q_item, .q_pop
    );

    lrip_back u_back (
        .clk, .rst_n, .q_valid, .q_item, .q_pop, .min_range(min_range_reg),
        .out_valid, .out_stall, .status, .row, .column, .cell_index, .range,
        .out_x, .out_y, .out_z, .out_intensity
    );
endmodule

@@ test/lidar_range_image_projection_tb.sv @@
// Self-checking testbench for lidar_range_image_projection.
// Depends on lrip_pkg and the block; a built-in predictor checks every result.
`timescale 1ns / 1ps

module lidar_range_image_projection_tb;
    import lrip_pkg::*;

    // One input item and one expected result, at the block's widths.
    typedef struct {
        bit                 scan;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [7:0]         inten;
        logic [7:0]         ring;
    } point_t;

    typedef struct {
        logic [2:0]         status;
        logic [7:0]         row;
        logic [10:0]        column;
        logic [15:0]        cell_index;
        logic [23:0]        range;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [7:0]         inten;
    } proj_t;

    // Arctangent steps in 1/2^32 turn.
    localparam longint ANGLE_STEP [CORDIC_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [7:0]         intensity;
    logic [7:0]         ring;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic [7:0]         row;
    logic [10:0]        column;
    logic [15:0]        cell_index;
    logic [23:0]        range;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [7:0]         out_intensity;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;

    lidar_range_image_projection uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .intensity(intensity), .ring(ring),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .row(row), .column(column), .cell_index(cell_index),
        .range(range), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .out_intensity(out_intensity),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state: registers, occupancy map and per-row arrival counters.
    bit          col_from_counter;
    int unsigned keep_every;
    int unsigned near_limit;
    bit          cell_busy [CELLS];
    int unsigned arrivals [ROWS];

    point_t pending_q [$];
    proj_t  expected_q [$];

    int tx_idle_pct;
    int rx_idle_pct;
    bit tx_pause;
    int rx_hold_req;
    int rx_hold_done;
    int rx_hold_left;
    int mismatches;
    point_t last_pt;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Divide by 65536, rounding half away from zero.
    function automatic longint round_turn16(longint n);
        if (n >= 0)
            return (n + 32768) >>> 16;
        return -((-n + 32768) >>> 16);
    endfunction

    // Azimuth atan2(num, den) in 1/65536 turn by vectoring CORDIC.
    function automatic longint azimuth_turns(longint num, longint den);
        longint xv, yv, acc, nx, ny;
        xv = den;
        yv = num;
        acc = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            acc = (yv >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
            xv = -xv;
            yv = -yv;
        end
        xv = xv * (64'sd1 <<< 30);
        yv = yv * (64'sd1 <<< 30);
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (yv >= 0)
            begin
                nx = xv + (yv >>> i);
                ny = yv - (xv >>> i);
                acc += ANGLE_STEP[i];
            end
            else
            begin
                nx = xv - (yv >>> i);
                ny = yv + (xv >>> i);
                acc -= ANGLE_STEP[i];
            end
            xv = nx;
            yv = ny;
        end
        return round_turn16(acc);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned s);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Project one item onto the image and update the map.
    function automatic proj_t project_point(point_t p);
        proj_t r;
        longint xs, ys, zs, c, a;
        longint unsigned dist_v;
        int unsigned rate, cell_idx;
        r = '{default: '0};
        if (p.scan)
        begin
            foreach (cell_busy[i]) cell_busy[i] = 1'b0;
            foreach (arrivals[i]) arrivals[i] = 0;
            r.status = ST_CLEARED;
            return r;
        end
        xs = p.x;
        ys = p.y;
        zs = p.z;
        dist_v = floor_sqrt(xs * xs + ys * ys + zs * zs);
        r.row = p.ring;
        r.range = dist_v[23:0];
        rate = (keep_every == 0) ? 1 : keep_every;
        if (p.ring >= ROWS)
        begin
            r.status = ST_RING_OUT;
            return r;
        end
        if (p.ring % rate != 0)
        begin
            r.status = ST_SKIPPED;
            return r;
        end
        if (col_from_counter)
        begin
            c = arrivals[p.ring];
            if (arrivals[p.ring] < COLS)
                arrivals[p.ring]++;
        end
        else
        begin
            a = azimuth_turns(xs, ys);
            c = COLS / 2 - round_turn16((a - 16384) * COLS);
            if (c >= COLS)
                c -= COLS;
            if (c < 0)
                c += COLS;
        end
        if (c < 0 || c >= COLS)
        begin
            r.status = ST_COL_OUT;
            return r;
        end
        r.column = c[10:0];
        cell_idx = c + p.ring * COLS;
        if (dist_v < near_limit)
            r.status = ST_NEAR;
        else if (cell_busy[cell_idx])
            r.status = ST_OCCUPIED;
        else
        begin
            cell_busy[cell_idx] = 1'b1;
            r.status = ST_PLACED;
            r.cell_index = cell_idx[15:0];
            r.x = p.x;
            r.y = p.y;
            r.z = p.z;
            r.inten = p.inten;
        end
        return r;
    endfunction

    // Append one item to the tail of the pending list.
    function automatic void queue_item(point_t p);
        pending_q = {pending_q, p};
    endfunction

    // Driver: predict on acceptance, then offer the next item or idle.
    always @(posedge clk or negedge rst_n)
    begin : driver
        point_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= 1'b0;
            pos_x <= '0;
            pos_y <= '0;
            pos_z <= '0;
            intensity <= '0;
            ring <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_q = {expected_q, project_point(pending_q[0])};
                pending_q.delete(0);
            end
            // hold a stalled item unchanged
            if (!(in_valid && in_stall))
            begin
                if (pending_q.size() > 0 && !tx_pause &&
                    $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    nxt = pending_q[0];
                    in_valid <= 1'b1;
                    mode <= nxt.scan;
                    pos_x <= nxt.x;
                    pos_y <= nxt.y;
                    pos_z <= nxt.z;
                    intensity <= nxt.inten;
                    ring <= nxt.ring;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here on request from the sequence.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold_left <= 0;
            rx_hold_done <= 0;
        end
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
        else if (rx_hold_done != rx_hold_req)
        begin
            rx_hold_left <= 600;
            rx_hold_done <= rx_hold_req;
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        proj_t e;
        bit bad;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: status %0d row %0d column %0d",
                                 status, row, column);
                end
                else
                begin
                    e = expected_q[0];
                    expected_q.delete(0);
                    bad = e.status !== status || e.row !== row ||
                          e.column !== column || e.cell_index !== cell_index ||
                          e.range !== range || e.x !== out_x || e.y !== out_y ||
                          e.z !== out_z || e.inten !== out_intensity;
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: expected st %0d row %0d col %0d cell %0d ",
                                      "rng %0d xyz %0d %0d %0d i %0d; got st %0d row %0d ",
                                      "col %0d cell %0d rng %0d xyz %0d %0d %0d i %0d"},
                                     e.status, e.row, e.column, e.cell_index, e.range,
                                     e.x, e.y, e.z, e.inten, status, row, column,
                                     cell_index, range, out_x, out_y, out_z,
                                     out_intensity);
                    end
                end
            end
            out_stall <= (rx_hold_left != 0) || ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    function automatic logic signed [23:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return '0;
            3: return $urandom_range(0, 4095) - 2048;
            4: return $urandom_range(0, 65535) - 32768;
            default: return $urandom();
        endcase
    endfunction

    function automatic point_t make_point(bit one_row);
        point_t p;
        // repeat a point now and then to hit an occupied cell
        if (!one_row && $urandom_range(0, 99) < 12)
            return last_pt;
        p.scan = 1'b0;
        p.x = pick_coord();
        p.y = pick_coord();
        p.z = pick_coord();
        p.inten = $urandom();
        if (one_row)
            p.ring = 0;
        else if ($urandom_range(0, 99) < 85)
            p.ring = $urandom_range(0, ROWS - 1);
        else
            p.ring = $urandom();
        last_pt = p;
        return p;
    endfunction

    function automatic point_t mk(bit sc, int x, int y, int z, int i, int rg);
        point_t p;
        p.scan = sc;
        p.x = x;
        p.y = y;
        p.z = z;
        p.inten = i;
        p.ring = rg;
        return p;
    endfunction

    function automatic point_t new_scan();
        point_t p;
        p = make_point(1'b0);
        p.scan = 1'b1;
        return p;
    endfunction

    task automatic drain();
        while (pending_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_COLUMN_MODE: col_from_counter = data[0];
            REG_DOWNSAMPLE:  keep_every = data[6:0];
            REG_MIN_RANGE:   near_limit = data[23:0];
            default: ;
        endcase
    endtask

    // One phase: write the settings, then queue items with a new scan first.
    task automatic run_phase(bit cm, int unsigned rate, int unsigned minr, int n,
                             bit one_row);
        write_reg(REG_COLUMN_MODE, cm);
        write_reg(REG_DOWNSAMPLE, rate);
        write_reg(REG_MIN_RANGE, minr);
        queue_item(new_scan());
        for (int k = 0; k < n; k++)
            queue_item(make_point(one_row));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tx_pause = 1'b0;
        rx_hold_req = 0;
        mismatches = 0;
        col_from_counter = 1'b0;
        keep_every = 1;
        near_limit = 1024;
        foreach (cell_busy[i]) cell_busy[i] = 1'b0;
        foreach (arrivals[i]) arrivals[i] = 0;
        last_pt = mk(0, 1000, 1000, 0, 1, 0);
        tx_idle_pct = 21;
        rx_idle_pct = 60;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under reset settings: extremes, out-of-range rings, near and occupied cells, new scan.
        queue_item(mk(0, 8388607, 0, 0, 255, 0));
        queue_item(mk(0, -8388608, -8388608, -8388608, 0, 15));
        queue_item(mk(0, 8388607, 8388607, 8388607, 170, 1));
        queue_item(mk(0, 0, 0, 0, 85, 2));
        queue_item(mk(0, 0, 5000, 0, 1, 3));
        queue_item(mk(0, 0, -5000, 0, 2, 3));
        queue_item(mk(0, -5000, 1, 0, 3, 3));
        queue_item(mk(0, -5000, -1, 0, 4, 3));
        queue_item(mk(0, -5000, 0, 0, 5, 4));
        queue_item(mk(0, 3000, 3000, 100, 6, 5));
        queue_item(mk(0, 3000, 3000, 100, 7, 5));
        queue_item(mk(0, 1023, 0, 0, 8, 6));
        queue_item(mk(0, 1024, 0, 0, 9, 6));
        queue_item(mk(0, 4000, 100, 0, 10, 16));
        queue_item(mk(0, 4000, 100, 0, 11, 255));
        queue_item(mk(1, -1, -1, -1, 255, 255));
        queue_item(mk(0, 3000, 3000, 100, 12, 5));
        queue_item(mk(0, -8388608, 8388607, 0, 13, 7));
        drain();

        run_phase(1'b0, 1, 0, 150, 1'b0);
        drain();
        // long receiver hold-off so the block backs up and stalls its input
        run_phase(1'b1, 2, 1024, 150, 1'b0);
        rx_hold_req++;
        drain();

        tx_idle_pct = 60;
        rx_idle_pct = 21;
        run_phase(1'b0, 64, 16777215, 100, 1'b0);
        drain();
        run_phase(1'b0, 3, 5000, 100, 1'b0);
        // pause the sender until every expected result has come
        while (pending_q.size() > 50)
            @(posedge clk);
        tx_pause = 1'b1;
        while (expected_q.size() != 0)
            @(posedge clk);
        tx_pause = 1'b0;
        for (int k = 0; k < 100; k++)
            queue_item(make_point(1'b0));
        drain();
        run_phase(1'b1, 1, 0, 200, 1'b0);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(1'b0, 0, 100, 100, 1'b0);
        drain();
        run_phase(1'b0, 7, 16777215, 30, 1'b0);
        drain();

        if (mismatches == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
